// ===== rtl/core/fdde_pkg.sv =====
// Shared constants and types for the flared disk density evaluator.
package fdde_pkg;

    // Default number of fraction bits in the fixed-point formats.
    localparam int FRAC_BITS_DEFAULT = 16;

    // Width of every configuration register, input field and density word.
    localparam int WORD_W = 32;

    // The scale height saturates at this width.
    localparam int HGT_W = 64;

    // Number of Horner steps in the exponential series.
    localparam int HORNER_STEPS = 12;

    // pi / (4 ln 2) and ln 2, both in Q30, and one in Q30.
    localparam logic [30:0] EXP_SCALE = 31'd1216646161;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_INNER_RADIUS    = 3'd0,
        REG_OUTER_RADIUS    = 3'd1,
        REG_RADIAL_SCALE    = 3'd2,
        REG_AXIAL_SCALE     = 3'd3,
        REG_CENTRAL_DENSITY = 3'd4
    } fdde_reg_t;

    // Per-item flags that travel beside the data through the pipeline.
    typedef struct packed {
        logic outside;
        logic h_zero;
        logic z_nonzero;
    } fdde_flags_t;

endpackage

// ===== rtl/core/fdde_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
module fdde_div #(
    parameter int NUM_W  = 32,
    parameter int DEN_W  = 32,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DEN_W-1:0]  in_rem,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [NUM_W-1:0]  out_quot,
    output logic [SIDE_W-1:0] out_side
);

    logic [NUM_W-1:0]  vld_reg;
    logic [DEN_W-1:0]  rem_reg  [NUM_W];
    logic [NUM_W-1:0]  nq_reg   [NUM_W];
    logic [DEN_W-1:0]  den_reg  [NUM_W];
    logic [SIDE_W-1:0] side_reg [NUM_W];
    logic [DEN_W-1:0]  rem_next [NUM_W];
    logic [NUM_W-1:0]  nq_next  [NUM_W];

    // One subtract-and-compare per stage; the numerator shifts out as the
    // quotient shifts in. The partial remainder stays below the divisor.
    for (genvar i = 0; i < NUM_W; i++)
    begin : g_step
        logic [DEN_W-1:0] p_rem;
        logic [DEN_W-1:0] p_den;
        logic [NUM_W-1:0] p_nq;
        logic [DEN_W:0]   trial;
        logic             ge;

        if (i == 0)
        begin : g_first
            assign p_rem = in_rem;
            assign p_nq  = in_num;
            assign p_den = in_den;
        end
        else
        begin : g_later
            assign p_rem = rem_reg[i-1];
            assign p_nq  = nq_reg[i-1];
            assign p_den = den_reg[i-1];
        end

        assign trial       = {p_rem, p_nq[NUM_W-1]};
        assign ge          = (trial >= {1'b0, p_den});
        assign rem_next[i] = ge ? DEN_W'(trial - {1'b0, p_den}) : trial[DEN_W-1:0];
        assign nq_next[i]  = {p_nq[NUM_W-2:0], ge};
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NUM_W-2:0], in_valid};
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_W; i++)
            begin
                rem_reg[i] <= rem_next[i];
                nq_reg[i]  <= nq_next[i];
            end
            den_reg[0]  <= in_den;
            side_reg[0] <= in_side;
            for (int i = 1; i < NUM_W; i++)
            begin
                den_reg[i]  <= den_reg[i-1];
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign out_valid = vld_reg[NUM_W-1];
    assign out_quot  = nq_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];

endmodule

// ===== rtl/core/fdde_sqrt.sv =====
// Pipelined integer square root, one root bit per register stage.
module fdde_sqrt #(
    parameter int RAD_W  = 32,
    parameter int SIDE_W = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [RAD_W-1:0]     in_rad,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic [RAD_W/2-1:0]   out_root,
    output logic [SIDE_W-1:0]    out_side
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic [ROOT_W-1:0] vld_reg;
    logic [RAD_W-1:0]  rad_reg   [ROOT_W];
    logic [REM_W-1:0]  rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [SIDE_W-1:0] side_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_next  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];

    // Each stage brings down the next pair of radicand bits and tries 4r+1.
    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_step
        logic [RAD_W-1:0]  p_rad;
        logic [REM_W-1:0]  p_rem;
        logic [ROOT_W-1:0] p_root;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              ge;

        if (i == 0)
        begin : g_first
            assign p_rad  = in_rad;
            assign p_rem  = '0;
            assign p_root = '0;
        end
        else
        begin : g_later
            assign p_rad  = rad_reg[i-1];
            assign p_rem  = rem_reg[i-1];
            assign p_root = root_reg[i-1];
        end

        assign rem_sh       = {p_rem[REM_W-3:0], p_rad[RAD_W-1:RAD_W-2]};
        assign trial        = {p_root, 2'b01};
        assign ge           = (rem_sh >= trial);
        assign rem_next[i]  = ge ? (rem_sh - trial) : rem_sh;
        assign root_next[i] = {p_root[ROOT_W-2:0], ge};
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[ROOT_W-2:0], in_valid};
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < ROOT_W; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
            end
            rad_reg[0]  <= {in_rad[RAD_W-3:0], 2'b00};
            side_reg[0] <= in_side;
            for (int i = 1; i < ROOT_W; i++)
            begin
                rad_reg[i]  <= {rad_reg[i-1][RAD_W-3:0], 2'b00};
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

// ===== rtl/core/fdde_exp.sv =====
// Pipelined exp(-x) in Q30 by a twelve-step Horner series, three stages a step.
module fdde_exp
    import fdde_pkg::*;
#(
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [29:0]       in_x,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [30:0]       out_r,
    output logic [SIDE_W-1:0] out_side
);

    logic [29:0]       x_c    [HORNER_STEPS+1];
    logic [30:0]       r_c    [HORNER_STEPS+1];
    logic              v_c    [HORNER_STEPS+1];
    logic [SIDE_W-1:0] side_c [HORNER_STEPS+1];

    assign x_c[0]    = in_x;
    assign r_c[0]    = ONE_Q30;
    assign v_c[0]    = in_valid;
    assign side_c[0] = in_side;

    // Step j works r = 1 - (x*r)/k with k running from twelve down to one.
    // The division by k is a reciprocal multiply, then one correction.
    for (genvar j = 0; j < HORNER_STEPS; j++)
    begin : g_term
        localparam int K = HORNER_STEPS - j;
        localparam logic [31:0] RECIP = 32'(64'hFFFF_FFFF / K);

        logic              a_vld_reg, b_vld_reg, c_vld_reg;
        logic [29:0]       a_m_reg, a_x_reg;
        logic [SIDE_W-1:0] a_side_reg;
        logic [29:0]       b_q_reg, b_m_reg, b_x_reg;
        logic [SIDE_W-1:0] b_side_reg;
        logic [30:0]       c_r_reg;
        logic [29:0]       c_x_reg;
        logic [SIDE_W-1:0] c_side_reg;
        logic [60:0]       a_prod;
        logic [61:0]       b_prod;
        logic [29:0]       c_kq;
        logic [29:0]       c_rem;
        logic [29:0]       c_quot;

        assign a_prod = 61'(x_c[j]) * 61'(r_c[j]);
        assign b_prod = 62'(a_m_reg) * 62'(RECIP);
        assign c_kq   = 30'(b_q_reg * 30'(K));
        assign c_rem  = b_m_reg - c_kq;
        assign c_quot = (c_rem >= 30'(K)) ? (b_q_reg + 30'd1) : b_q_reg;

        // Valid bits of the three stages.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_vld_reg <= 1'b0;
                b_vld_reg <= 1'b0;
                c_vld_reg <= 1'b0;
            end
            else if (en)
            begin
                a_vld_reg <= v_c[j];
                b_vld_reg <= a_vld_reg;
                c_vld_reg <= b_vld_reg;
            end
        end

        // Product, reciprocal multiply, then correction and subtraction.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_m_reg    <= a_prod[59:30];
                a_x_reg    <= x_c[j];
                a_side_reg <= side_c[j];
                b_q_reg    <= b_prod[61:32];
                b_m_reg    <= a_m_reg;
                b_x_reg    <= a_x_reg;
                b_side_reg <= a_side_reg;
                c_r_reg    <= ONE_Q30 - 31'(c_quot);
                c_x_reg    <= b_x_reg;
                c_side_reg <= b_side_reg;
            end
        end

        assign x_c[j+1]    = c_x_reg;
        assign r_c[j+1]    = c_r_reg;
        assign v_c[j+1]    = c_vld_reg;
        assign side_c[j+1] = c_side_reg;
    end

    assign out_valid = v_c[HORNER_STEPS];
    assign out_r     = r_c[HORNER_STEPS];
    assign out_side  = side_c[HORNER_STEPS];

endmodule

// ===== rtl/core/flared_disk_density_eval_core.sv =====
// Top level of the flared disk density evaluator.
//
// The slave stream carries one point a beat: tdata holds radius in bits 31:0
// and height in bits 63:32. The master stream returns one beat per point:
// tdata holds the density, tuser bit 0 the saturation flag and bit 1 the
// flag for a radius outside the disk. Registers are to be written through
// the plain write port only while no point is in flight; the block itself
// does not enforce it. The block takes one beat in every cycle while the
// pipeline is not held. A point passes through three pipelined dividers,
// three square roots and the twelve Horner steps of the exponential.
// Reset clears every valid bit and loads the register defaults: radii 1.0
// and 10.0, both scales 1.0 and a central density of 1.0.
// Results enter a two-beat output queue. When the receiver stalls the queue
// fills and then the whole pipeline holds, dropping s_tready; no beat is
// lost or repeated.
module flared_disk_density_eval_core
    import fdde_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // radius [31:0], height [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // density [31:0]
    output logic [1:0]  m_tuser,   // saturated [0], outside [1]
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [31:0] wr_data
);

    localparam int F       = FRAC_BITS;
    localparam int QW      = WORD_W + F;
    localparam int RAD1_W  = QW + F;
    localparam int R1W     = RAD1_W / 2;
    localparam int RAD2_W  = R1W + F;
    localparam int R2W     = RAD2_W / 2;
    localparam int RAD3_W  = R2W + F;
    localparam int R3W     = RAD3_W / 2;
    localparam int HQW     = QW + R3W - F;
    localparam int HLO     = HQW / 2;
    localparam int HHI     = HQW - HLO;
    localparam int HPW     = HQW + WORD_W;
    localparam int HSH_W   = HPW - F;
    localparam int U_LIM   = F + 3;
    localparam int TW      = 2 * U_LIM - F;
    localparam int S_W     = TW + 31 - F;
    localparam int NUM_PW  = WORD_W + 31;
    localparam int FD_W    = QW + 30 - F;
    localparam int FL_W    = $bits(fdde_flags_t);
    localparam int SQ_SW   = QW + WORD_W + 1;
    localparam int D2_SW   = QW + FL_W;
    localparam int EX_SW   = QW + 8;
    localparam int OUT_W   = WORD_W + 2;

    // Configuration registers.
    logic [WORD_W-1:0] inner_reg, outer_reg, rscale_reg, ascale_reg, cdens_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_reg  <= WORD_W'(1) << F;
            outer_reg  <= WORD_W'(10) << F;
            rscale_reg <= WORD_W'(1) << F;
            ascale_reg <= WORD_W'(1) << F;
            cdens_reg  <= WORD_W'(1) << F;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_INNER_RADIUS:    inner_reg  <= wr_data;
                REG_OUTER_RADIUS:    outer_reg  <= wr_data;
                REG_RADIAL_SCALE:    rscale_reg <= wr_data;
                REG_AXIAL_SCALE:     ascale_reg <= wr_data;
                REG_CENTRAL_DENSITY: cdens_reg  <= wr_data;
                default:             ;
            endcase
        end
    end

    // Pipeline advance: hold everything only when a result is ready and the
    // output queue is full.
    logic       adv;
    logic       d3_valid;
    logic [1:0] count_reg;

    assign adv      = !(d3_valid && (count_reg == 2'd2));
    assign s_tready = adv;

    // Input decode: height magnitude, disk bounds and the radial divisor.
    logic [WORD_W-1:0] in_r, in_z, in_zm, rdiv;
    logic              in_outside;

    assign in_r       = s_tdata[31:0];
    assign in_z       = s_tdata[63:32];
    assign in_zm      = in_z[WORD_W-1] ? (~in_z + WORD_W'(1)) : in_z;
    assign in_outside = (in_r < inner_reg) || (in_r > outer_reg);
    assign rdiv       = (rscale_reg == '0) ? WORD_W'(1) : rscale_reg;

    // q = radius / radial scale.
    logic              d1_valid;
    logic [QW-1:0]     d1_q;
    logic [WORD_W:0]   d1_side;

    fdde_div #(.NUM_W(QW), .DEN_W(WORD_W), .SIDE_W(WORD_W + 1)) u_div_q (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .in_valid(s_tvalid),
        .in_rem('0),
        .in_num({in_r, F'(0)}),
        .in_den(rdiv),
        .in_side({in_outside, in_zm}),
        .out_valid(d1_valid),
        .out_quot(d1_q),
        .out_side(d1_side)
    );

    // q^(1/8) by three square roots.
    logic             s1_valid, s2_valid, s3_valid;
    logic [R1W-1:0]   s1_root;
    logic [R2W-1:0]   s2_root;
    logic [R3W-1:0]   s3_root;
    logic [SQ_SW-1:0] s1_side, s2_side, s3_side;

    fdde_sqrt #(.RAD_W(RAD1_W), .SIDE_W(SQ_SW)) u_sqrt_1 (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .in_valid(d1_valid),
        .in_rad({d1_q, F'(0)}),
        .in_side({d1_q, d1_side}),
        .out_valid(s1_valid),
        .out_root(s1_root),
        .out_side(s1_side)
    );

    fdde_sqrt #(.RAD_W(RAD2_W), .SIDE_W(SQ_SW)) u_sqrt_2 (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .in_valid(s1_valid),
        .in_rad({s1_root, F'(0)}),
        .in_side(s1_side),
        .out_valid(s2_valid),
        .out_root(s2_root),
        .out_side(s2_side)
    );

    fdde_sqrt #(.RAD_W(RAD3_W), .SIDE_W(SQ_SW)) u_sqrt_3 (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .in_valid(s2_valid),
        .in_rad({s2_root, F'(0)}),
        .in_side(s2_side),
        .out_valid(s3_valid),
        .out_root(s3_root),
        .out_side(s3_side)
    );

    // Scale height h = ((q * q8) >> F) * axial >> F, in three stages.
    logic [QW-1:0]         s3_q;
    logic [QW+R3W-1:0]     m1_prod;
    logic [HLO+WORD_W-1:0] m2_plo;
    logic [HHI+WORD_W-1:0] m2_phi;
    logic [HPW-1:0]        m3_sum;
    logic [HSH_W-1:0]      m3_hsh;
    logic [HGT_W-1:0]      m3_h;

    logic                  m1_vld_reg, m2_vld_reg, m3_vld_reg;
    logic [HQW-1:0]        m1_hq_reg;
    logic [QW-1:0]         m1_q_reg, m2_q_reg, m3_q_reg;
    logic                  m1_out_reg, m2_out_reg;
    logic [WORD_W-1:0]     m1_zm_reg, m2_zm_reg, m3_zm_reg;
    logic [HLO+WORD_W-1:0] m2_plo_reg;
    logic [HHI+WORD_W-1:0] m2_phi_reg;
    logic [HGT_W-1:0]      m3_h_reg;
    fdde_flags_t           m3_flags_reg;

    assign s3_q    = s3_side[SQ_SW-1:WORD_W+1];
    assign m1_prod = (QW+R3W)'(s3_q) * (QW+R3W)'(s3_root);
    assign m2_plo  = (HLO+WORD_W)'(m1_hq_reg[HLO-1:0]) * (HLO+WORD_W)'(ascale_reg);
    assign m2_phi  = (HHI+WORD_W)'(m1_hq_reg[HQW-1:HLO]) * (HHI+WORD_W)'(ascale_reg);
    assign m3_sum  = HPW'(m2_plo_reg) + (HPW'(m2_phi_reg) << HLO);
    assign m3_hsh  = m3_sum[HPW-1:F];
    assign m3_h    = (|m3_hsh[HSH_W-1:HGT_W]) ? '1 : m3_hsh[HGT_W-1:0];

    // Height over scale height.
    logic             d2_valid;
    logic [QW-1:0]    d2_u;
    logic [D2_SW-1:0] d2_side;

    fdde_div #(.NUM_W(QW), .DEN_W(HGT_W), .SIDE_W(D2_SW)) u_div_u (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .in_valid(m3_vld_reg),
        .in_rem('0),
        .in_num({m3_zm_reg, F'(0)}),
        .in_den(m3_h_reg),
        .in_side({m3_q_reg, m3_flags_reg}),
        .out_valid(d2_valid),
        .out_quot(d2_u),
        .out_side(d2_side)
    );

    // Exponent: t = u^2, s = t * pi/(4 ln 2), x = frac(s) * ln 2.
    // A quotient of eight or more drives the factor to zero anyway.
    fdde_flags_t          d2_flags;
    logic [2*U_LIM-1:0]   e1_usq;
    logic [TW+30:0]       e2_sp;
    logic [S_W-1:0]       e2_s;
    logic [59:0]          e3_xp;

    logic                 e1_vld_reg, e2_vld_reg, e3_vld_reg;
    logic [TW-1:0]        e1_t_reg;
    logic                 e1_big_reg;
    fdde_flags_t          e1_flags_reg;
    logic [QW-1:0]        e1_q_reg, e2_q_reg, e3_q_reg;
    logic [29:0]          e2_f_reg;
    logic [4:0]           e2_n_reg, e3_n_reg;
    logic                 e2_zero_reg, e2_one_reg, e2_out_reg;
    logic                 e3_zero_reg, e3_one_reg, e3_out_reg;
    logic [29:0]          e3_x_reg;

    assign d2_flags = d2_side[FL_W-1:0];
    assign e1_usq   = (2*U_LIM)'(d2_u[U_LIM-1:0]) * (2*U_LIM)'(d2_u[U_LIM-1:0]);
    assign e2_sp    = (TW+31)'(e1_t_reg) * (TW+31)'(EXP_SCALE);
    assign e2_s     = e2_sp[TW+30:F];
    assign e3_xp    = 60'(e2_f_reg) * 60'(LN2_Q30);

    // Horner series for exp(-x).
    logic             ex_valid;
    logic [30:0]      ex_r;
    logic [EX_SW-1:0] ex_side;

    fdde_exp #(.SIDE_W(EX_SW)) u_exp (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .in_valid(e3_vld_reg),
        .in_x(e3_x_reg),
        .in_side({e3_q_reg, e3_out_reg, e3_zero_reg, e3_one_reg, e3_n_reg}),
        .out_valid(ex_valid),
        .out_r(ex_r),
        .out_side(ex_side)
    );

    // Factor g = 2^-n * exp(-x), then the numerator central density * g.
    logic              ex_one, ex_zero;
    logic [4:0]        ex_n;
    logic [30:0]       g_val;
    logic              g_vld_reg, p_vld_reg;
    logic [30:0]       g_g_reg;
    logic [QW-1:0]     g_q_reg, p_q_reg;
    logic              g_out_reg, p_out_reg;
    logic [NUM_PW-1:0] p_num_reg;

    assign ex_n    = ex_side[4:0];
    assign ex_one  = ex_side[5];
    assign ex_zero = ex_side[6];
    assign g_val   = ex_one ? ONE_Q30 : (ex_zero ? 31'd0 : (ex_r >> ex_n));

    // Final division by q scaled to Q30; a high half not below the divisor
    // means the quotient does not fit the density word.
    logic [FD_W-1:0] fd_den;
    logic [FD_W-1:0] fd_hi;
    logic            fd_qzero;
    logic            fd_sat;

    assign fd_den   = {p_q_reg, (30 - F)'(0)};
    assign fd_hi    = FD_W'(p_num_reg[NUM_PW-1:WORD_W]);
    assign fd_qzero = (p_q_reg == '0);
    assign fd_sat   = fd_qzero ? (p_num_reg != '0) : (fd_hi >= fd_den);

    logic [WORD_W-1:0] d3_quot;
    logic [1:0]        d3_side;

    // With q at zero the numerator is either zero or saturates, so a divisor
    // of one gives the zero density in the first case.
    fdde_div #(.NUM_W(WORD_W), .DEN_W(FD_W), .SIDE_W(2)) u_div_d (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .in_valid(p_vld_reg),
        .in_rem(fd_sat ? '0 : fd_hi),
        .in_num(p_num_reg[WORD_W-1:0]),
        .in_den(fd_qzero ? FD_W'(1) : fd_den),
        .in_side({p_out_reg, fd_sat}),
        .out_valid(d3_valid),
        .out_quot(d3_quot),
        .out_side(d3_side)
    );

    // Valid bits of the stages held in this module.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
            e1_vld_reg <= 1'b0;
            e2_vld_reg <= 1'b0;
            e3_vld_reg <= 1'b0;
            g_vld_reg  <= 1'b0;
            p_vld_reg  <= 1'b0;
        end
        else if (adv)
        begin
            m1_vld_reg <= s3_valid;
            m2_vld_reg <= m1_vld_reg;
            m3_vld_reg <= m2_vld_reg;
            e1_vld_reg <= d2_valid;
            e2_vld_reg <= e1_vld_reg;
            e3_vld_reg <= e2_vld_reg;
            g_vld_reg  <= ex_valid;
            p_vld_reg  <= g_vld_reg;
        end
    end

    // Stage payload of the multiply, exponent and factor stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_hq_reg  <= m1_prod[QW+R3W-1:F];
            m1_q_reg   <= s3_q;
            m1_out_reg <= s3_side[WORD_W];
            m1_zm_reg  <= s3_side[WORD_W-1:0];

            m2_plo_reg <= m2_plo;
            m2_phi_reg <= m2_phi;
            m2_q_reg   <= m1_q_reg;
            m2_out_reg <= m1_out_reg;
            m2_zm_reg  <= m1_zm_reg;

            m3_h_reg               <= m3_h;
            m3_q_reg               <= m2_q_reg;
            m3_zm_reg              <= m2_zm_reg;
            m3_flags_reg.outside   <= m2_out_reg;
            m3_flags_reg.h_zero    <= (m3_h == '0);
            m3_flags_reg.z_nonzero <= (m2_zm_reg != '0);

            e1_t_reg     <= e1_usq[2*U_LIM-1:F];
            e1_big_reg   <= |d2_u[QW-1:U_LIM];
            e1_flags_reg <= d2_flags;
            e1_q_reg     <= d2_side[D2_SW-1:FL_W];

            e2_f_reg    <= e2_s[29:0];
            e2_n_reg    <= e2_s[34:30];
            e2_zero_reg <= e1_big_reg || (e2_s[S_W-1:30] >= (S_W-30)'(31))
                           || (e1_flags_reg.h_zero && e1_flags_reg.z_nonzero);
            e2_one_reg  <= e1_flags_reg.h_zero && !e1_flags_reg.z_nonzero;
            e2_out_reg  <= e1_flags_reg.outside;
            e2_q_reg    <= e1_q_reg;

            e3_x_reg    <= e3_xp[59:30];
            e3_n_reg    <= e2_n_reg;
            e3_zero_reg <= e2_zero_reg;
            e3_one_reg  <= e2_one_reg;
            e3_out_reg  <= e2_out_reg;
            e3_q_reg    <= e2_q_reg;

            g_g_reg   <= g_val;
            g_q_reg   <= ex_side[EX_SW-1:8];
            g_out_reg <= ex_side[7];

            p_num_reg <= NUM_PW'(cdens_reg) * NUM_PW'(g_g_reg);
            p_q_reg   <= g_q_reg;
            p_out_reg <= g_out_reg;
        end
    end

    // Result assembly: outside wins, then saturation.
    logic [OUT_W-1:0] res;
    logic             res_out, res_sat;

    assign res_out = d3_side[1];
    assign res_sat = !res_out && d3_side[0];
    assign res     = {res_out, res_sat,
                      res_out ? WORD_W'(0) : (res_sat ? '1 : d3_quot)};

    // Two-beat output queue.
    logic [OUT_W-1:0] slot0_reg, slot1_reg;
    logic             wr_ptr_reg, rd_ptr_reg;
    logic             push, pop;
    logic [OUT_W-1:0] head;

    assign push = d3_valid && adv;
    assign pop  = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !wr_ptr_reg)
        begin
            slot0_reg <= res;
        end
        if (push && wr_ptr_reg)
        begin
            slot1_reg <= res;
        end
    end

    assign head     = rd_ptr_reg ? slot1_reg : slot0_reg;
    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = head[WORD_W-1:0];
    assign m_tuser  = head[OUT_W-1:WORD_W];

    // The queue never holds more than two beats.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("output queue overflow");

    // A point outside the disk gives zero density and no saturation.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tdata == '0 && !m_tuser[0]))
        else $error("outside point with non-zero result");

    // A saturated result is all ones.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '1))
        else $error("saturated result not all ones");

    // A stalled pipeline with a full queue keeps its last result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!adv && !pop) |=> (d3_valid && $stable(d3_quot)))
        else $error("stalled result changed");

endmodule
